@@ hw/rtl/positional_list_engine_unit_defines.svh @@
// Assertion helpers for the list engine RTL, used by plc_seq.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Clocked check on clk, switched off while rst is high.
`define PLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that a condition never holds.
`define PLC_ASSERT_NEVER(lbl, cond, msg) \
  `PLC_ASSERT(lbl, !(cond), msg)

`endif

@@ hw/rtl/plc_pkg.sv @@
`default_nettype none
package plc_pkg;

  localparam int PLC_CAPACITY = 128;
  localparam int CMD_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } plc_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        list_count;
    logic                    is_empty;
  } plc_rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } plc_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/positional_list_engine_unit.sv @@
// Channel  Direction  Beat        Handshake
// cmd      in         plc_cmd_t   cmd_valid / cmd_ready
// rsp      out        plc_rsp_t   rsp_valid / rsp_ready
//
// Insert, clear, unused codes and rejected commands go from accept through start to done and the rsp beat.
// Read and find add a scan between start and done: the cell row rotates once past cell 0.
// Delete adds the rotation, then one shift of the row, before done.
// One command is in flight at a time; a new one is taken while a beat waits in rsp.
// Synchronous reset empties the list at once; cell contents are not cleared.
`default_nettype none
module positional_list_engine_unit #(
  parameter int CAPACITY = plc_pkg::PLC_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire plc_pkg::plc_cmd_t cmd,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output plc_pkg::plc_rsp_t      rsp
);
  import plc_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  cell_ctrl_t              ctrl;
  logic [IdxW-1:0]         pos_idx;
  logic [CntW-1:0]         len;
  logic signed [VAL_W-1:0] cell_value [CAPACITY];

  plc_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head_value(cell_value[0]),
    .ctrl      (ctrl),
    .pos_idx   (pos_idx),
    .len       (len)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plc_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .pos_idx(pos_idx),
      .len    (len),
      .left   ((i == 0) ? ctrl.value : cell_value[(i == 0) ? 0 : i - 1]),
      .right  (cell_value[(i == CAPACITY - 1) ? 0 : i + 1]),
      .value  (cell_value[i])
    );
  end

endmodule
`default_nettype wire

@@ hw/rtl/plc_cell.sv @@
`default_nettype none
module plc_cell #(
  parameter int CAPACITY = plc_pkg::PLC_CAPACITY,
  parameter int INDEX = 0,
  localparam int IdxW = $clog2(CAPACITY),
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic                            clk,
  input  wire plc_pkg::cell_ctrl_t             ctrl,
  input  wire logic [IdxW-1:0]                 pos_idx,
  input  wire logic [CntW-1:0]                 len,
  input  wire logic signed [plc_pkg::VAL_W-1:0] left,
  input  wire logic signed [plc_pkg::VAL_W-1:0] right,
  output logic signed [plc_pkg::VAL_W-1:0]      value
);
  import plc_pkg::*;

  localparam logic [CntW-1:0] MyIdx  = CntW'(INDEX);
  localparam logic [CntW-1:0] MyNext = CntW'(INDEX + 1);

  logic [CntW-1:0]         pos_ext;
  logic signed [VAL_W-1:0] value_next;

  assign pos_ext = CntW'(pos_idx);

  always_comb begin
    value_next = value;
    case (ctrl.op)
      CELL_INSERT: begin
        if (MyIdx == pos_ext) begin
          value_next = ctrl.value;
        end else if (MyIdx > pos_ext && MyIdx <= len) begin
          value_next = left;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= pos_ext && MyNext < len) begin
          value_next = right;
        end
      end
      CELL_ROTATE: value_next = right;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

@@ hw/rtl/plc_seq.sv @@
`default_nettype none
`include "positional_list_engine_unit_defines.svh"
module plc_seq #(
  parameter int CAPACITY = plc_pkg::PLC_CAPACITY,
  localparam int IdxW = $clog2(CAPACITY),
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire plc_pkg::plc_cmd_t                cmd,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output plc_pkg::plc_rsp_t                     rsp,
  input  wire logic signed [plc_pkg::VAL_W-1:0] head_value,
  output plc_pkg::cell_ctrl_t                   ctrl,
  output logic [IdxW-1:0]                       pos_idx,
  output logic [CntW-1:0]                       len
);
  import plc_pkg::*;

  localparam int VW = ((CntW > POS_W) ? CntW : POS_W) + 1;
  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  plc_state_t              state, state_next;
  plc_cmd_t                item, item_next;
  logic [CntW-1:0]         len_next;
  logic [IdxW-1:0]         scan_idx, scan_next;
  logic [CntW-1:0]         scan_cnt;
  logic [ST_W-1:0]         res_status, status_next;
  logic signed [VAL_W-1:0] res_value, value_next;
  logic [POS_W-1:0]        res_fpos, fpos_next;
  logic                    rsp_valid_next;
  plc_rsp_t                rsp_next;
  logic [VW-1:0]           pos_w;
  logic [VW-1:0]           len_w;
  logic                    ins_bad;
  logic                    acc_bad;

  assign pos_w    = VW'(item.position);
  assign len_w    = VW'(len);
  assign pos_idx  = IdxW'(pos_w - VW'(1));
  assign scan_cnt = CntW'(scan_idx);
  assign ins_bad  = (item.position == '0) || (pos_w > len_w + VW'(1));
  assign acc_bad  = (item.position == '0) || (pos_w > len_w);

  always_comb begin
    state_next     = state;
    item_next      = item;
    len_next       = len;
    scan_next      = scan_idx;
    status_next    = res_status;
    value_next     = res_value;
    fpos_next      = res_fpos;
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    cmd_ready      = 1'b0;
    ctrl.op        = CELL_HOLD;
    ctrl.value     = item.value_in;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          item_next  = cmd;
          state_next = S_START;
        end
      end
      S_START: begin
        status_next = ST_OK;
        value_next  = '0;
        fpos_next   = '0;
        state_next  = S_DONE;
        unique case (item.command) inside
          CMD_INSERT: begin
            if (ins_bad) begin
              status_next = ST_BADPOS;
            end else if (len == CapCnt) begin
              status_next = ST_FULL;
            end else begin
              ctrl.op  = CELL_INSERT;
              len_next = len + CntW'(1);
            end
          end
          CMD_DELETE, CMD_READ: begin
            if (acc_bad) begin
              status_next = ST_BADPOS;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_FIND: begin
            status_next = ST_NOTFOUND;
            state_next  = S_SCAN;
          end
          CMD_CLEAR: len_next = '0;
          default: ;
        endcase
      end
      S_SCAN: begin
        ctrl.op   = CELL_ROTATE;
        scan_next = scan_idx + IdxW'(1);
        if ((item.command == CMD_DELETE || item.command == CMD_READ) &&
            scan_idx == pos_idx) begin
          value_next = head_value;
        end
        if (item.command == CMD_FIND && res_status == ST_NOTFOUND &&
            scan_cnt < len && head_value == item.value_in) begin
          status_next = ST_OK;
          fpos_next   = POS_W'(scan_cnt + CntW'(1));
        end
        if (scan_idx == LastIdx) begin
          scan_next  = '0;
          state_next = (item.command == CMD_DELETE) ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        ctrl.op    = CELL_DELETE;
        len_next   = len - CntW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next          = 1'b1;
          rsp_next.status         = res_status;
          rsp_next.value_out      = res_value;
          rsp_next.found_position = res_fpos;
          rsp_next.list_count     = POS_W'(len);
          rsp_next.is_empty       = (len == '0);
          state_next              = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      scan_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      scan_idx  <= scan_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    res_status <= status_next;
    res_value  <= value_next;
    res_fpos   <= fpos_next;
    rsp        <= rsp_next;
  end

  `PLC_ASSERT_NEVER(a_len_bound, len > CapCnt, "List length exceeds capacity.")
  `PLC_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> $past(state == S_DONE), "Beat not from done.")
  `PLC_ASSERT(a_len_change, (len != $past(len)) |-> ($past(state == S_START) || $past(state == S_SHIFT)), "Length changed outside an update step.")
  `PLC_ASSERT(a_shift_after_scan, (state == S_SHIFT) |-> ($past(state == S_SCAN) && item.command == CMD_DELETE), "Shift without a delete scan.")
  `PLC_ASSERT(a_scan_idle_zero, (state != S_SCAN) |-> (scan_idx == '0), "Scan counter not parked.")

endmodule
`default_nettype wire
